// ===== rtl/fhan_pkg.sv =====
// ----------------------------------------------------------------------------
// fhan_pkg: shared constants for the fhan pipeline.
// Holds the configuration register index width and the register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package fhan_pkg;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/fhan_sqrt.sv =====
// ----------------------------------------------------------------------------
// fhan_sqrt: pipelined integer square root, one result bit per stage.
// Computes the floor root of an unsigned radicand and carries a sideband word.
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_sqrt
	import fhan_pkg::*;
#(
	parameter int RW = 128,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [RW-1:0] radicand,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [RW/2-1:0]    root,
	output logic [SW-1:0]      out_side
);
	localparam int QW = RW / 2;
	logic [QW:0]      v_s1;
	logic [RW-1:0]    n_s1 [QW+1];
	logic [QW-1:0]    q_s1 [QW+1];
	logic [SW-1:0]    sd_s1 [QW+1];

	always_comb begin
		v_s1[0]  = in_valid;
		n_s1[0]  = radicand;
		q_s1[0]  = '0;
		sd_s1[0] = in_side;
	end

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [QW-1:0] cand;
		logic [RW-1:0] sq;
		always_comb begin
			cand = q_s1[g] | (QW'(1) << (QW - 1 - g));
			sq   = RW'(cand) * RW'(cand);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[g+1] <= 1'b0;
			end else begin
				v_s1[g+1] <= v_s1[g];
			end
		end
		always_ff @(posedge clk) begin
			n_s1[g+1]  <= n_s1[g];
			sd_s1[g+1] <= sd_s1[g];
			q_s1[g+1]  <= (sq <= n_s1[g]) ? cand : q_s1[g];
		end
	end

	assign out_valid = v_s1[QW];
	assign root      = q_s1[QW];
	assign out_side  = sd_s1[QW];
endmodule
`default_nettype wire

// ===== rtl/fhan_div.sv =====
// ----------------------------------------------------------------------------
// fhan_div: pipelined restoring divider, one quotient bit per stage.
// Divides an unsigned dividend by a nonzero divisor and carries a sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_div
	import fhan_pkg::*;
#(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [NW-1:0]      quotient,
	output logic [SW-1:0]      out_side
);
	logic [NW:0]   v_s1;
	logic [NW-1:0] n_s1 [NW+1];
	logic [DW:0]   r_s1 [NW+1];
	logic [DW-1:0] d_s1 [NW+1];
	logic [SW-1:0] sd_s1 [NW+1];

	always_comb begin
		v_s1[0]  = in_valid;
		n_s1[0]  = dividend;
		r_s1[0]  = '0;
		d_s1[0]  = divisor;
		sd_s1[0] = in_side;
	end

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [DW+1:0] sh;
		always_comb sh = {r_s1[g], n_s1[g][NW-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[g+1] <= 1'b0;
			end else begin
				v_s1[g+1] <= v_s1[g];
			end
		end
		always_ff @(posedge clk) begin
			d_s1[g+1]  <= d_s1[g];
			sd_s1[g+1] <= sd_s1[g];
			if (sh >= {2'b00, d_s1[g]}) begin
				r_s1[g+1] <= (DW+1)'(sh - {2'b00, d_s1[g]});
				n_s1[g+1] <= {n_s1[g][NW-2:0], 1'b1};
			end else begin
				r_s1[g+1] <= (DW+1)'(sh);
				n_s1[g+1] <= {n_s1[g][NW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s1[NW];
	assign quotient  = n_s1[NW];
	assign out_side  = sd_s1[NW];
endmodule
`default_nettype wire

// ===== rtl/adrc_fhan_optimal_control_unit.sv =====
// ----------------------------------------------------------------------------
// adrc_fhan_optimal_control_unit: pipelined ADRC fhan time-optimal function.
//
// Channel    Signals                                   Direction
// config     cfg_we, cfg_index, cfg_data               in
// item in    start, busy, position_error, rate_error   in (busy out)
// result     done, accel_command, saturated            out
//
// One item may enter in every cycle; busy is always low. The pipe has
// four front stages for d, a0, y, t and the radicand, DATA_WIDTH stages of
// square root, two stages to select the branch, 2*DATA_WIDTH stages of divider
// and one output stage. The divider is the longest part of the pipe.
// Reset clears only the valid bits and loads the two config registers with their defaults. The receiver cannot
// stall, so a result leaves on done for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module adrc_fhan_optimal_control_unit
	import fhan_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [30:0]          cfg_data,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [31:0]   position_error,
	input  wire logic signed [31:0]   rate_error,
	output logic                      done,
	output logic signed [31:0]        accel_command,
	output logic                      saturated
);
	localparam int W  = DATA_WIDTH;
	localparam int XW = 2 * W + 4;
	localparam logic signed [XW-1:0] DMAX = XW'((65'sd1 <<< (W - 1)) - 1);
	localparam logic signed [XW-1:0] DMIN = -DMAX - 1;

	// Generic clamp of a wide signed value to the datapath range.
	function automatic logic signed [W:0] clampw(input logic signed [XW-1:0] v);
		logic signed [W:0] res;
		if (v > DMAX)      res = {1'b1, DMAX[W-1:0]};
		else if (v < DMIN) res = {1'b1, DMIN[W-1:0]};
		else               res = {1'b0, v[W-1:0]};
		return res;
	endfunction

	// Truncating Q product of two datapath values with clamp; bit W is the flag.
	function automatic logic [W:0] qmul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W-1:0]   ma, mb;
		logic [2*W-1:0] p, s;
		logic           neg, ov;
		logic [W-1:0]   lim, v;
		ma  = a[W-1] ? W'(-a) : W'(a);
		mb  = b[W-1] ? W'(-b) : W'(b);
		neg = a[W-1] ^ b[W-1];
		p   = (2*W)'(ma) * (2*W)'(mb);
		s   = p >> FRAC_BITS;
		lim = neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
		ov  = (s > (2*W)'(lim));
		v   = ov ? lim : s[W-1:0];
		return {ov, neg ? W'(-v) : v};
	endfunction

	logic [30:0] speed_q, step_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 31'd6553600;
			step_q  <= 31'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED: speed_q <= cfg_data;
				REG_STEP:  step_q  <= cfg_data;
				default:   ;
			endcase
		end
	end
	assign busy = 1'b0;

	logic signed [W-1:0] r_w, h_w;
	logic [W:0] rc, hc, x1c, x2c;
	always_comb begin
		rc  = clampw(XW'($signed({1'b0, speed_q})));
		hc  = clampw(XW'($signed({1'b0, step_q})));
		x1c = clampw(XW'(position_error));
		x2c = clampw(XW'(rate_error));
		r_w = rc[W-1:0];
		h_w = hc[W-1:0];
	end

	// Stage 1: r*h, h*x2, input clamps.
	logic v_s1, f_s1;
	logic signed [W-1:0] rh_s1, a0_s1, x1_s1, r_s1, h_s1;
	logic [W:0] p_rh, p_a0;
	always_comb begin
		p_rh = qmul(r_w, h_w);
		p_a0 = qmul(h_w, x2c[W-1:0]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		rh_s1 <= p_rh[W-1:0];
		a0_s1 <= p_a0[W-1:0];
		x1_s1 <= x1c[W-1:0];
		r_s1  <= r_w;
		h_s1  <= h_w;
		f_s1  <= rc[W] | hc[W] | x1c[W] | x2c[W] | p_rh[W] | p_a0[W];
	end

	// Stage 2: d = rh*h, y = x1 + a0.
	logic v_s2, f_s2;
	logic signed [W-1:0] d_s2, y_s2, a0_s2, r_s2;
	logic [W:0] p_d, s_y;
	always_comb begin
		p_d = qmul(rh_s1, h_s1);
		s_y = clampw(XW'(x1_s1) + XW'(a0_s1));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		d_s2  <= p_d[W-1:0];
		y_s2  <= s_y[W-1:0];
		a0_s2 <= a0_s1;
		r_s2  <= r_s1;
		f_s2  <= f_s1 | p_d[W] | s_y[W];
	end

	// Stage 3: t = d + 8|y|.
	logic v_s3, f_s3;
	logic signed [W-1:0] t_s3;
	logic signed [W-1:0] d_s3, y_s3, a0_s3, r_s3;
	logic [XW-1:0] my;
	logic [W:0] s_t;
	always_comb begin
		my  = y_s2[W-1] ? XW'(-XW'(y_s2)) : XW'(y_s2);
		s_t = clampw(XW'(d_s2) + (my <<< 3));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		t_s3  <= s_t[W-1:0];
		d_s3  <= d_s2;
		y_s3  <= y_s2;
		a0_s3 <= a0_s2;
		r_s3  <= r_s2;
		f_s3  <= f_s2 | s_t[W];
	end

	// Stage 4: radicand product, registered before the root pipe.
	logic v_s4;
	logic [2*W-1:0] rad_s4;
	logic [4*W:0] side_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		rad_s4  <= (2*W)'($unsigned(d_s3)) * (2*W)'($unsigned(t_s3));
		side_s4 <= {f_s3, d_s3, y_s3, a0_s3, r_s3};
	end

	logic sq_v;
	logic [W-1:0] sq_root;
	logic [4*W:0] sq_side;
	fhan_sqrt #(.RW(2 * W), .SW(4 * W + 1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s4), .radicand(rad_s4),
		.in_side(side_s4), .out_valid(sq_v), .root(sq_root), .out_side(sq_side)
	);

	// Stage 5: branch select for a.
	logic signed [W-1:0] d_q5, y_q5, a0_q5, r_q5;
	logic f_q5;
	logic [W:0] a1c, a2c, aly;
	logic signed [XW-1:0] half;
	always_comb begin
		{f_q5, d_q5, y_q5, a0_q5, r_q5} = sq_side;
		a1c  = clampw(XW'({1'b0, sq_root}));
		half = (XW'(a1c[W-1:0]) - XW'(d_q5)) >>> 1;
		a2c  = clampw(y_q5[W-1] ? XW'(a0_q5) - half : XW'(a0_q5) + half);
		aly  = clampw(XW'(a0_q5) + XW'(y_q5));
	end
	logic v_s5, f_s5;
	logic signed [W-1:0] a_s5, d_s5, r_s5;
	logic lin;
	always_comb lin = (y_q5 >= -XW'(d_q5)) && (y_q5 < d_q5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= sq_v;
	end
	// The switching value a2 is always formed, so its clip counts on both branches.
	always_ff @(posedge clk) begin
		a_s5 <= lin ? aly[W-1:0] : a2c[W-1:0];
		d_s5 <= d_q5;
		r_s5 <= r_q5;
		f_s5 <= f_q5 | a1c[W] | a2c[W] | (lin & aly[W]) | (d_q5 == '0);
	end

	// Stage 6: r*|a| and the branch decision for fhan.
	logic v_s6;
	logic [2*W-1:0] num_s6;
	logic [W-1:0] den_s6;
	logic [W+2:0] sd6;
	logic fl;
	always_comb fl = (d_s5 > 0) && (a_s5 >= -XW'(d_s5)) && (a_s5 < d_s5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		num_s6 <= (2*W)'($unsigned(r_s5)) *
			(2*W)'(a_s5[W-1] ? W'(-a_s5) : W'(a_s5));
		den_s6 <= fl ? W'(d_s5) : W'(1);
		sd6    <= {f_s5, fl, a_s5[W-1], r_s5};
	end

	logic dv_v;
	logic [2*W-1:0] quo;
	logic [W+2:0] dv_side;
	fhan_div #(.NW(2 * W), .DW(W), .SW(W + 3)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s6), .dividend(num_s6),
		.divisor(den_s6), .in_side(sd6), .out_valid(dv_v), .quotient(quo),
		.out_side(dv_side)
	);

	// Output stage: sign, clamp to datapath and to the port range.
	logic fo, flo, an;
	logic signed [W-1:0] ro;
	logic signed [XW-1:0] fh;
	logic [W:0] fc;
	logic signed [XW-1:0] fcx;
	logic o_ov;
	always_comb begin
		{fo, flo, an, ro} = dv_side;
		if (flo) fh = an ? XW'(quo) : -XW'(quo);
		else     fh = an ? XW'(ro) : -XW'(ro);
		fc   = clampw(fh);
		fcx  = XW'($signed(fc[W-1:0]));
		o_ov = (fcx > XW'(32'sh7fffffff)) || (fcx < XW'(-33'sh80000000));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv_v;
	end
	always_ff @(posedge clk) begin
		accel_command <= o_ov ? (fcx[XW-1] ? 32'sh80000000 : 32'sh7fffffff)
			: fcx[31:0];
		saturated     <= fo | fc[W] | o_ov;
	end

	a_busy: assert property (@(posedge clk) busy == 1'b0)
		else $error("busy raised");
	a_s1: assert property (@(posedge clk) disable iff (!arst_n) start |=> v_s1)
		else $error("item lost in stage one");
	a_s2: assert property (@(posedge clk) disable iff (!arst_n) v_s1 |=> v_s2)
		else $error("item lost in stage two");
	a_done: assert property (@(posedge clk) disable iff (!arst_n) dv_v |=> done)
		else $error("result lost at output");
endmodule
`default_nettype wire

// ===== sim/tb_adrc_fhan_optimal_control_unit.sv =====
// ----------------------------------------------------------------------------
// tb_adrc_fhan_optimal_control_unit: self-checking bench for the fhan unit.
// A directed table covers the register extremes and the zero-d cases, then
// random phases sweep r, h and the error inputs. Every item is predicted
// bit for bit (or typed in the table) and compared with the result strobed on done.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_adrc_fhan_optimal_control_unit;
	import fhan_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint QMAX = 64'sh7FFFFFFF;
	localparam longint QMIN = -QMAX - 1;
	// Depth of the unit's pipe, summed from the stage counts in the top-level header.
	localparam int LATENCY = 103;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [30:0] cfg_data;
	logic start;
	logic busy;
	logic signed [31:0] position_error;
	logic signed [31:0] rate_error;
	logic done;
	logic signed [31:0] accel_command;
	logic saturated;

	typedef struct {
		logic signed [31:0] accel;
		logic sat;
	} fhan_result_t;

	// Expected results, oldest first.
	fhan_result_t pending_cmds[$];
	int err_count;
	int idle_cycles;
	// Model copy of the two configuration registers.
	longint speed_r;
	longint step_h;

	adrc_fhan_optimal_control_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.position_error(position_error), .rate_error(rate_error),
		.done(done), .accel_command(accel_command), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Clamp to the signed datapath range; any clip raises the flag.
	function automatic longint clip(input logic signed [127:0] v, inout bit f);
		if (v > QMAX) begin
			f = 1'b1;
			return QMAX;
		end
		if (v < QMIN) begin
			f = 1'b1;
			return QMIN;
		end
		return longint'(v[63:0]);
	endfunction

	function automatic logic [127:0] mag(input longint v);
		logic signed [127:0] w;
		w = v;
		return (w < 0) ? -w : w;
	endfunction

	// Q16.16 product, truncated toward zero in magnitude, clamped.
	function automatic longint qmul(input longint a, input longint b, inout bit f);
		logic [127:0] p;
		logic [127:0] s;
		logic [127:0] lim;
		bit neg;
		neg = (a < 0) != (b < 0);
		p = mag(a) * mag(b);
		s = p >> 16;
		lim = neg ? 128'h80000000 : 128'h7FFFFFFF;
		if (s > lim) begin
			f = 1'b1;
			s = lim;
		end
		return neg ? -longint'(s[63:0]) : longint'(s[63:0]);
	endfunction

	function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
		logic [127:0] res;
		logic [127:0] c;
		res = '0;
		for (int b = 62; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if (c * c <= n) res = c;
		end
		return res;
	endfunction

	// Full fhan for one item under the current register copy.
	function automatic fhan_result_t fhan_predict(input logic signed [31:0] x1_in,
			input logic signed [31:0] x2_in);
		fhan_result_t res;
		bit f;
		longint x1, x2, rh, d, a0, y, t, a1, half, a2, a, fh;
		logic [127:0] q;
		f = 1'b0;
		x1 = x1_in;
		x2 = x2_in;
		rh = qmul(speed_r, step_h, f);
		d = qmul(rh, step_h, f);
		a0 = qmul(step_h, x2, f);
		y = clip(x1 + a0, f);
		t = clip(d + 8 * mag(y), f);
		a1 = clip(floor_sqrt(mag(d) * mag(t)), f);
		half = (a1 - d) >>> 1;
		a2 = clip((y >= 0) ? a0 + half : a0 - half, f);
		if (y >= -d && y < d) a = clip(a0 + y, f);
		else a = a2;
		if (d == 0) f = 1'b1;
		if (d > 0 && a >= -d && a < d) begin
			q = (mag(speed_r) * mag(a)) / mag(d);
			fh = (a >= 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		end else begin
			fh = (a >= 0) ? -speed_r : speed_r;
		end
		fh = clip(fh, f);
		res.accel = fh[31:0];
		res.sat = f;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// Result checker and stall watchdog, both sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_cmds.size() == 0) begin
					report_mismatch("unexpected result, accel", accel_command, 0);
				end else begin
					fhan_result_t exp_r;
					exp_r = pending_cmds.pop_front();
					if (accel_command !== exp_r.accel)
						report_mismatch("accel_command", accel_command, exp_r.accel);
					if (saturated !== exp_r.sat)
						report_mismatch("saturated", saturated, exp_r.sat);
				end
			end
			if (done || (start && !busy) || cfg_we) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_adrc_fhan_optimal_control_unit: FAIL");
				$finish;
			end
		end
	end

	// Registers are only written once the pipe has drained.
	task automatic drain_pipe();
		while (pending_cmds.size() != 0) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[30:0];
		@(posedge clk);
		if (idx == REG_SPEED) speed_r = val & 64'h7FFFFFFF;
		else step_h = val & 64'h7FFFFFFF;
	endtask

	task automatic set_config(input longint r, input longint h);
		start <= 1'b0;
		@(posedge clk);
		drain_pipe();
		write_reg(REG_SPEED, r);
		write_reg(REG_STEP, h);
		cfg_we <= 1'b0;
	endtask

	// Offers one item; start stays high so the next item can follow directly.
	task automatic send_item(input logic signed [31:0] x1, input logic signed [31:0] x2,
			input bit typed, input fhan_result_t typed_res);
		start <= 1'b1;
		position_error <= x1;
		rate_error <= x2;
		do @(posedge clk); while (busy);
		pending_cmds.push_back(typed ? typed_res : fhan_predict(x1, x2));
	endtask

	task automatic random_gap();
		int gap;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) gap = 0;
		else if (sel < 92) gap = $urandom_range(1, 4);
		else gap = $urandom_range(20, 150);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic longint pick_reg(input bit is_step);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 0;
		if (sel == 1) return 64'h7FFFFFFF;
		if (sel == 2) return {$urandom()} & 64'h7FFFFFFF;
		if (is_step) return $urandom_range(1, 131072);
		return $urandom_range(65536, 65536 * 800);
	endfunction

	// Errors near the d scale reach the linear branch; full-range ones the rest.
	function automatic logic signed [31:0] pick_err();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) return $urandom();
		if (sel < 8) return $signed($urandom_range(0, 8191)) - 4096;
		if (sel == 8) return $signed($urandom_range(0, 2097151)) - 1048576;
		return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
	endfunction

	typedef struct {
		longint r;
		longint h;
		logic signed [31:0] x1;
		logic signed [31:0] x2;
		bit typed;
		logic signed [31:0] accel;
		logic sat;
	} stim_row_t;

	// Typed rows: with r = 0 the output is zero and flagged; with h = 0 the
	// state collapses to a = 0, so the output is -r and flagged.
	stim_row_t stim_table[] = '{
		'{6553600, 655, 32'sd0, 32'sd0, 0, 0, 0},
		'{6553600, 655, 32'sd100, 32'sd0, 0, 0, 0},
		'{6553600, 655, -32'sd100, 32'sd0, 0, 0, 0},
		'{6553600, 655, 32'sd653, -32'sd65536, 0, 0, 0},
		'{6553600, 655, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0},
		'{6553600, 655, 32'sh80000000, 32'sh80000000, 0, 0, 0},
		'{6553600, 655, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0},
		'{6553600, 655, -32'sd654, 32'sd0, 0, 0, 0},
		'{6553600, 655, 32'sd654, 32'sd0, 0, 0, 0},
		'{0, 655, 32'sd12345, -32'sd999, 1, 32'sd0, 1'b1},
		'{0, 655, 32'sh80000000, 32'sh7FFFFFFF, 1, 32'sd0, 1'b1},
		'{0, 32'h7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0},
		'{32'h7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh80000000, 1, -32'sd2147483647, 1'b1},
		'{32'h7FFFFFFF, 0, -32'sd5, 32'sd77, 1, -32'sd2147483647, 1'b1},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'sd0, 32'sd0, 0, 0, 0},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'sh80000000, 32'sh80000000, 0, 0, 0},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'sh7FFFFFFF, -32'sd1, 0, 0, 0},
		'{65536, 65536, 32'sd32768, -32'sd65536, 0, 0, 0},
		'{65536, 65536, -32'sd65536, 32'sd0, 0, 0, 0},
		'{65536, 65536, 32'sd65535, 32'sd0, 0, 0, 0},
		'{65536, 65536, 32'sd65536, 32'sd0, 0, 0, 0}
	};

	initial begin
		fhan_result_t typed_res;
		longint r;
		longint h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SPEED;
		cfg_data = '0;
		start = 1'b0;
		position_error = '0;
		rate_error = '0;
		err_count = 0;
		idle_cycles = 0;
		speed_r = 6553600;
		step_h = 655;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: first rows run on the reset values of r and h.
		foreach (stim_table[i]) begin
			if (stim_table[i].r != speed_r || stim_table[i].h != step_h)
				set_config(stim_table[i].r, stim_table[i].h);
			typed_res.accel = stim_table[i].accel;
			typed_res.sat = stim_table[i].sat;
			send_item(stim_table[i].x1, stim_table[i].x2, stim_table[i].typed, typed_res);
			random_gap();
		end

		// Random part: ten register settings, 95 items each.
		for (int phase = 0; phase < 10; phase++) begin
			r = pick_reg(1'b0);
			h = pick_reg(1'b1);
			set_config(r, h);
			for (int n = 0; n < 95; n++) begin
				send_item(pick_err(), pick_err(), 1'b0, typed_res);
				if (phase % 3 != 0) random_gap();
			end
		end

		start <= 1'b0;
		drain_pipe();
		repeat (LATENCY + 10) @(posedge clk);
		if (err_count == 0 && pending_cmds.size() == 0) begin
			$display("tb_adrc_fhan_optimal_control_unit: PASS");
		end else begin
			$display("tb_adrc_fhan_optimal_control_unit: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
